### src/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  // Component width and the number of quotient bits each divider lane resolves
  localparam int COMP_W  = 8;
  localparam int QUO_W   = 10;
  localparam int HUE_W   = 11;
  localparam int STEPS   = QUO_W;

  // One full hue turn in sector steps (six sectors of 256)
  localparam logic [11:0] HUE_TURN = 12'd1536;

  // Hue sector codes, already scaled to the sector start
  typedef enum logic [2:0] {
    SECT_RED   = 3'd0,
    SECT_GREEN = 3'd2,
    SECT_BLUE  = 3'd4
  } sect_t;

  // Word handed from cell to cell along the divider chain
  typedef struct packed {
    logic [COMP_W-1:0] delta;
    logic [COMP_W-1:0] bright;
    logic              gray;
    sect_t             sect;
    logic [COMP_W-1:0] hue_rem;
    logic [QUO_W-1:0]  hue_num;
    logic [QUO_W-1:0]  hue_quo;
    logic [COMP_W-1:0] sat_rem;
    logic [QUO_W-1:0]  sat_num;
    logic [QUO_W-1:0]  sat_quo;
  } div_word_t;

endpackage

`default_nettype wire

### src/rhc_prep.sv
// Front stage: max, min, delta, hue sector and divider numerators.
`default_nettype none

module rhc_prep (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      pix_valid,
  input  wire logic [rhc_pkg::COMP_W-1:0] red,
  input  wire logic [rhc_pkg::COMP_W-1:0] green,
  input  wire logic [rhc_pkg::COMP_W-1:0] blue,
  output logic                           word_valid,
  output rhc_pkg::div_word_t             word
);

  logic [rhc_pkg::COMP_W-1:0] mx_rg, mn_rg, mx, mn, delta;
  logic [8:0]                 span;
  logic [15:0]                sat_n;
  rhc_pkg::sect_t             sect;

  // Find the largest and smallest component
  always_comb begin
    if (red > green) begin
      mx_rg = red;
      mn_rg = green;
    end else begin
      mx_rg = green;
      mn_rg = red;
    end
    mx    = (blue > mx_rg) ? blue : mx_rg;
    mn    = (blue < mn_rg) ? blue : mn_rg;
    delta = mx - mn;
  end

  // Pick the sector; span is difference plus delta, so never negative
  always_comb begin
    if (red == mx) begin
      sect = rhc_pkg::SECT_RED;
      span = {1'b0, green} - {1'b0, blue} + {1'b0, delta};
    end else if (green == mx) begin
      sect = rhc_pkg::SECT_GREEN;
      span = {1'b0, blue} - {1'b0, red} + {1'b0, delta};
    end else begin
      sect = rhc_pkg::SECT_BLUE;
      span = {1'b0, red} - {1'b0, green} + {1'b0, delta};
    end
    // 255 * delta as a shift and subtract
    sat_n = {delta, 8'h00} - {8'h00, delta};
  end

  // Register the word; the top numerator bits seed the remainders
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (adv) begin
      word_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word.delta   <= delta;
      word.bright  <= mx;
      word.gray    <= (delta == '0);
      word.sect    <= sect;
      word.hue_rem <= {1'b0, span[8:2]};
      word.hue_num <= {span[1:0], 8'h00};
      word.hue_quo <= '0;
      word.sat_rem <= {2'b00, sat_n[15:10]};
      word.sat_num <= sat_n[9:0];
      word.sat_quo <= '0;
    end
  end

endmodule

`default_nettype wire

### src/rhc_cell.sv
// One divider cell: resolves one quotient bit of both the hue and saturation lanes.
`default_nettype none

module rhc_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire rhc_pkg::div_word_t in_word,
  output logic                    out_valid,
  output rhc_pkg::div_word_t      out_word
);

  logic [rhc_pkg::COMP_W:0]   hue_trial, sat_trial;
  logic                       hue_bit, sat_bit;
  logic [rhc_pkg::COMP_W-1:0] hue_rem_next, sat_rem_next;
  rhc_pkg::div_word_t         out_word_next;

  // Shift in the next numerator bit and try to subtract the divisor
  always_comb begin
    hue_trial    = {in_word.hue_rem, in_word.hue_num[rhc_pkg::QUO_W-1]};
    hue_bit      = (hue_trial >= {1'b0, in_word.delta});
    hue_rem_next = hue_bit ? rhc_pkg::COMP_W'(hue_trial - {1'b0, in_word.delta})
                           : hue_trial[rhc_pkg::COMP_W-1:0];
    sat_trial    = {in_word.sat_rem, in_word.sat_num[rhc_pkg::QUO_W-1]};
    sat_bit      = (sat_trial >= {1'b0, in_word.bright});
    sat_rem_next = sat_bit ? rhc_pkg::COMP_W'(sat_trial - {1'b0, in_word.bright})
                           : sat_trial[rhc_pkg::COMP_W-1:0];
  end

  // Build the word for the next cell
  always_comb begin
    out_word_next         = in_word;
    out_word_next.hue_rem = hue_rem_next;
    out_word_next.hue_num = {in_word.hue_num[rhc_pkg::QUO_W-2:0], 1'b0};
    out_word_next.hue_quo = {in_word.hue_quo[rhc_pkg::QUO_W-2:0], hue_bit};
    out_word_next.sat_rem = sat_rem_next;
    out_word_next.sat_num = {in_word.sat_num[rhc_pkg::QUO_W-2:0], 1'b0};
    out_word_next.sat_quo = {in_word.sat_quo[rhc_pkg::QUO_W-2:0], sat_bit};
  end

  // Hand the word on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= out_word_next;
    end
  end

endmodule

`default_nettype wire

### src/rhc_pack.sv
// Output stage: assembles the hue, wraps it to one turn and holds the result.
`default_nettype none

module rhc_pack (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire rhc_pkg::div_word_t         in_word,
  output logic                            hsv_valid,
  output logic [rhc_pkg::HUE_W-1:0]       hue,
  output logic [rhc_pkg::COMP_W-1:0]      saturation,
  output logic [rhc_pkg::COMP_W-1:0]      brightness
);

  logic [3:0]                sect_off;
  logic [11:0]               hue_sum;
  logic [rhc_pkg::HUE_W-1:0] hue_wrap;

  // Sector start plus five sectors (the span carried one extra sector), then wrap
  always_comb begin
    sect_off = {1'b0, in_word.sect} + 4'd5;
    hue_sum  = {sect_off, 8'h00} + {2'b00, in_word.hue_quo};
    hue_wrap = (hue_sum >= rhc_pkg::HUE_TURN)
             ? rhc_pkg::HUE_W'(hue_sum - rhc_pkg::HUE_TURN)
             : hue_sum[rhc_pkg::HUE_W-1:0];
  end

  // Output register; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (adv) begin
      hsv_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue        <= in_word.gray ? '0 : hue_wrap;
      saturation <= in_word.gray ? '0 : in_word.sat_quo[rhc_pkg::COMP_W-1:0];
      brightness <= in_word.bright;
    end
  end

endmodule

`default_nettype wire

### src/rgb_to_hsv_converter.sv
// RGB to HSV converter: top level with the chain of divider cells.
//
// Pixel channel: pix_valid, pix_stall, red, green, blue. A word is taken at a
// rising edge with pix_valid high and pix_stall low.
// Result channel: hsv_valid, hsv_stall, hue, saturation, brightness, taken
// the same way. Hue is in 1/1536 turns; gray and black give hue and
// saturation of zero.
// Throughput: one pixel per clock while the chain is not held. The path from
// acceptance to hsv_valid runs through the front stage, ten divider cells (one
// quotient bit each for hue and saturation) and the output register; the front
// stage loads at the accepting edge itself.
// The whole chain moves as one: while a result waits in the output register
// and hsv_stall is high, every stage holds and pix_stall is raised; a word
// arriving in an empty output register, or one being taken, lets the chain
// advance in that same cycle.
// Reset clears all valid flags; the chain is empty and ready at once, and
// no result appears until a pixel is taken.
`default_nettype none

module rgb_to_hsv_converter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pix_valid,
  output logic                            pix_stall,
  input  wire logic [rhc_pkg::COMP_W-1:0] red,
  input  wire logic [rhc_pkg::COMP_W-1:0] green,
  input  wire logic [rhc_pkg::COMP_W-1:0] blue,
  output logic                            hsv_valid,
  input  wire logic                       hsv_stall,
  output logic [rhc_pkg::HUE_W-1:0]       hue,
  output logic [rhc_pkg::COMP_W-1:0]      saturation,
  output logic [rhc_pkg::COMP_W-1:0]      brightness
);

  logic                adv;
  logic                chain_valid [rhc_pkg::STEPS+1];
  rhc_pkg::div_word_t  chain_word  [rhc_pkg::STEPS+1];

  // Advance everything unless a result is waiting and blocked
  assign adv       = !hsv_valid || !hsv_stall;
  assign pix_stall = !adv;

  rhc_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .pix_valid  (pix_valid),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .word_valid (chain_valid[0]),
    .word       (chain_word[0])
  );

  // Row of divider cells
  for (genvar i = 0; i < rhc_pkg::STEPS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  rhc_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (chain_valid[rhc_pkg::STEPS]),
    .in_word    (chain_word[rhc_pkg::STEPS]),
    .hsv_valid  (hsv_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  // Hue always lands inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hue < rhc_pkg::HUE_W'(rhc_pkg::HUE_TURN)))
    else $error("hue outside one turn");

  // Zero saturation only for gray, which also has zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && saturation == '0) |-> (hue == '0))
    else $error("gray pixel with non-zero hue");

  // Black pixel gives no saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && brightness == '0) |-> (saturation == '0))
    else $error("black pixel with saturation");

  // Pixels are refused only when a result is blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (hsv_valid && hsv_stall))
    else $error("pixel stall without a blocked result");

endmodule

`default_nettype wire

### sim/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for the RGB to HSV converter: directed table, random pixels, back-pressure.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter;

  localparam int CW             = rhc_pkg::COMP_W;
  localparam int HUE_W          = rhc_pkg::HUE_W;
  localparam int HUE_STEPS      = 256;
  localparam int COMP_MAX       = (1 << CW) - 1;
  localparam int FULL_TURN      = 6 * HUE_STEPS;
  localparam int RANDOM_BLOCKS  = 14;
  localparam int BLOCK_ITEMS    = 40;
  localparam int PRESSURE_ITEMS = 60;
  localparam int PRESSURE_HOLD  = 80;
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CW-1:0]    sat;
    logic [CW-1:0]    bright;
  } hsv_word_t;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    bit            typed;
    hsv_word_t     hsv;
  } pix_row_t;

  // Expected result word, with the pixel that caused it for messages
  typedef struct {
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    hsv_word_t     hsv;
  } hsv_expect_t;

  localparam int DIR_ROWS = 20;

  pix_row_t dir_rows [DIR_ROWS] = '{
    // black, white, greys: no hue, no saturation
    '{8'd0,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{11'd0,    8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{11'd0,    8'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{11'd0,    8'd0,   8'd1}},
    // primaries at full scale
    '{8'd255, 8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{11'd512,  8'd255, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{11'd1024, 8'd255, 8'd255}},
    // secondaries: ties for the maximum, red over green over blue
    '{8'd255, 8'd255, 8'd0,   1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd0,   8'd255, 8'd255, 1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd255, 8'd0,   8'd255, 1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd100, 8'd200, 8'd200, 1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd200, 8'd200, 8'd100, 1'b0, '{11'd0,    8'd0,   8'd0}},
    // red maximum with green below blue: hue wraps below a full turn
    '{8'd255, 8'd0,   8'd1,   1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd200, 8'd10,  8'd90,  1'b0, '{11'd0,    8'd0,   8'd0}},
    // smallest delta and smallest saturation
    '{8'd1,   8'd0,   8'd0,   1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd255, 8'd254, 8'd254, 1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd0,   8'd1,   8'd0,   1'b0, '{11'd0,    8'd0,   8'd0}},
    // alternating bit patterns and near-equal components
    '{8'hAA,  8'h55,  8'h0F,  1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'h55,  8'hAA,  8'hF0,  1'b0, '{11'd0,    8'd0,   8'd0}},
    '{8'd254, 8'd255, 8'd253, 1'b0, '{11'd0,    8'd0,   8'd0}}
  };

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                pix_valid  = 1'b0;
  logic                pix_stall;
  logic [CW-1:0]       red        = '0;
  logic [CW-1:0]       green      = '0;
  logic [CW-1:0]       blue       = '0;
  logic                hsv_valid;
  logic                hsv_stall  = 1'b0;
  logic [HUE_W-1:0]    hue;
  logic [CW-1:0]       saturation;
  logic [CW-1:0]       brightness;

  hsv_expect_t hsv_expected [$];
  int          mismatch_count = 0;
  int          pressure_req   = 0;

  rgb_to_hsv_converter DUT (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always #1 clk = ~clk;

  // Work out hue, saturation and value of one pixel
  function automatic hsv_word_t predict_hsv(input logic [CW-1:0] r, g, b);
    int        rv, gv, bv, mx, mn, delta, diff, sector, num;
    hsv_word_t res;
    rv = r;
    gv = g;
    bv = b;
    if (rv > gv) begin
      mx = rv;
      mn = gv;
    end else begin
      mx = gv;
      mn = rv;
    end
    if (bv > mx) mx = bv;
    if (bv < mn) mn = bv;
    delta      = mx - mn;
    res.hue    = '0;
    res.sat    = '0;
    res.bright = CW'(mx);
    // grey and black carry no hue and no saturation
    if (delta != 0 && mx != 0) begin
      res.sat = CW'(COMP_MAX * delta / mx);
      if (rv == mx) begin
        sector = rhc_pkg::SECT_RED;
        diff   = gv - bv;
      end else if (gv == mx) begin
        sector = rhc_pkg::SECT_GREEN;
        diff   = bv - rv;
      end else begin
        sector = rhc_pkg::SECT_BLUE;
        diff   = rv - gv;
      end
      // bias by a full turn so the division floors, then wrap
      num     = HUE_STEPS * (sector + 6) * delta + HUE_STEPS * diff;
      res.hue = HUE_W'((num / delta) % FULL_TURN);
    end
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)      return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 10);
    else                return $urandom_range(20, 40);
  endfunction

  // Draw a pixel, weighted towards ties, greys, small and extreme values
  task automatic pick_pixel(output logic [CW-1:0] r, g, b);
    int            kind;
    logic [CW-1:0] base;
    kind = $urandom_range(0, 99);
    base = CW'($urandom);
    r    = CW'($urandom);
    g    = CW'($urandom);
    b    = CW'($urandom);
    if (kind >= 40 && kind < 55) begin
      case ($urandom_range(0, 2))
        0:       g = r;
        1:       b = r;
        default: b = g;
      endcase
    end else if (kind >= 55 && kind < 62) begin
      g = r;
      b = r;
    end else if (kind >= 62 && kind < 77) begin
      r = CW'($urandom_range(0, 7));
      g = CW'($urandom_range(0, 7));
      b = CW'($urandom_range(0, 7));
    end else if (kind >= 77 && kind < 87) begin
      r = ($urandom_range(0, 2) == 0) ? base : (($urandom_range(0, 1) == 0) ? '0 : '1);
      g = ($urandom_range(0, 2) == 0) ? base : (($urandom_range(0, 1) == 0) ? '0 : '1);
      b = ($urandom_range(0, 2) == 0) ? base : (($urandom_range(0, 1) == 0) ? '0 : '1);
    end else if (kind >= 87) begin
      r = base + CW'($urandom_range(0, 3));
      g = base + CW'($urandom_range(0, 3));
      b = base + CW'($urandom_range(0, 3));
    end
  endtask

  // Offer one pixel word, hold it until taken, record its answer
  task automatic send_pixel(input logic [CW-1:0] r, g, b, input hsv_word_t hsv,
                            input bit no_gap);
    int          gap;
    hsv_expect_t entry;
    pix_valid <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (pix_stall !== 1'b0);
    entry.r   = r;
    entry.g   = g;
    entry.b   = b;
    entry.hsv = hsv;
    hsv_expected.push_back(entry);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("t=%0t MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stimulus: directed table, then random blocks with a pressure burst first and midway
  initial begin : pixel_source
    logic [CW-1:0] r, g, b;
    bit            steady;
    int            waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                 dir_rows[i].typed ? dir_rows[i].hsv
                                   : predict_hsv(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b),
                 1'b0);
    end

    for (int blk = 0; blk <= RANDOM_BLOCKS; blk++) begin
      // fill the pipe while the result side holds off
      if (blk == 0 || blk == RANDOM_BLOCKS / 2) begin
        pressure_req++;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
          pick_pixel(r, g, b);
          send_pixel(r, g, b, predict_hsv(r, g, b), 1'b1);
        end
      end
      if (blk < RANDOM_BLOCKS) begin
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < BLOCK_ITEMS; i++) begin
          pick_pixel(r, g, b);
          send_pixel(r, g, b, predict_hsv(r, g, b), steady);
        end
      end
    end
    pix_valid <= 1'b0;

    // drain, then watch for stray words
    waited = 0;
    while (hsv_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hsv_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", hsv_expected.size()));

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stall runs, plus a long hold on request
  initial begin : result_sink
    int run_left;
    int hold_left;
    int pressure_seen;
    bit run_stall;
    run_left      = 0;
    hold_left     = 0;
    pressure_seen = 0;
    run_stall     = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        hold_left     = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        hsv_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 99) < 35);
          if (run_stall) run_left = 1 + pick_gap();
          else run_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 12);
        end
        run_left--;
        hsv_stall <= run_stall;
      end
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin : result_check
    hsv_expect_t want;
    string       pix;
    if (rst === 1'b0 && hsv_valid === 1'b1 && hsv_stall === 1'b0) begin
      if (hsv_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected word: hue %0d sat %0d bright %0d",
                                  hue, saturation, brightness));
      end else begin
        want = hsv_expected.pop_front();
        pix  = $sformatf("rgb (%0d,%0d,%0d)", want.r, want.g, want.b);
        if (hue !== want.hsv.hue)
          report_mismatch($sformatf("%s: hue %0d, expected %0d", pix, hue, want.hsv.hue));
        if (saturation !== want.hsv.sat)
          report_mismatch($sformatf("%s: saturation %0d, expected %0d",
                                    pix, saturation, want.hsv.sat));
        if (brightness !== want.hsv.bright)
          report_mismatch($sformatf("%s: brightness %0d, expected %0d",
                                    pix, brightness, want.hsv.bright));
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    #400_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### rgb_to_hsv_converter.f
src/rhc_pkg.sv
src/rhc_prep.sv
src/rhc_cell.sv
src/rhc_pack.sv
src/rgb_to_hsv_converter.sv
sim/tb_rgb_to_hsv_converter.sv
